// File: rtl/core/rmvs_pkg.sv
package rmvs_pkg;

   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_D1   = 14'b00000000000010,
      ST_M1   = 14'b00000000000100,
      ST_DIV1 = 14'b00000000001000,
      ST_MEAN = 14'b00000000010000,
      ST_D2   = 14'b00000000100000,
      ST_M2   = 14'b00000001000000,
      ST_MUL1 = 14'b00000010000000,
      ST_TSH  = 14'b00000100000000,
      ST_MUL2 = 14'b00001000000000,
      ST_DIV2 = 14'b00010000000000,
      ST_VLD  = 14'b00100000000000,
      ST_SQRT = 14'b01000000000000,
      ST_DONE = 14'b10000000000000
   } state_type;

endpackage

// File: rtl/core/rmvs_alu.sv
module rmvs_alu import rmvs_pkg::*; #(
   parameter int WIDTH = 80
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             sub,
   output logic [WIDTH-1:0] result,
   output logic             carry
);

   logic [WIDTH-1:0] b_eff;

   // carry out of a subtract means no borrow, i.e. a >= b
   assign b_eff = sub ? ~op_b : op_b;
   assign {carry, result} = {1'b0, op_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};

endmodule

// File: rtl/core/running_mean_variance_stats.sv
// Welford running statistics over signed samples. One item is taken, then the
// block stalls its input until the result is built. The work is done in one
// shared wide adder/subtractor that runs, one bit per cycle, a restoring divide
// for the mean, a shift-add multiply for the variance term, a second multiply
// by n-1, a second restoring divide by n and a digit-by-digit square root. A
// result waiting on rsp_stall does not block the next item from being accepted.
module running_mean_variance_stats import rmvs_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH  = 32,
   parameter int FRAC_BITS    = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]              req_sample,
   input  logic                                        req_restart,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [COUNT_WIDTH-1:0]                      rsp_sample_count,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_min_value,
   output logic signed [SAMPLE_WIDTH-1:0]              rsp_max_value,
   output logic [SAMPLE_WIDTH-1:0]                     rsp_value_range,
   output logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0]    rsp_mean_value,
   output logic [2*SAMPLE_WIDTH+FRAC_BITS-2:0]         rsp_variance_value,
   output logic [(2*SAMPLE_WIDTH+FRAC_BITS)/2-1:0]     rsp_std_deviation
);

   localparam int MEAN_W  = SAMPLE_WIDTH + FRAC_BITS;
   localparam int D_W     = MEAN_W + 1;
   localparam int VAR_W   = 2*SAMPLE_WIDTH + FRAC_BITS - 1;
   localparam int STD_W   = (VAR_W + 1) / 2;
   localparam int P_A     = VAR_W + COUNT_WIDTH + 1;
   localparam int PROD_W  = (P_A > 2*D_W) ? P_A : 2*D_W;
   localparam int ODD     = FRAC_BITS % 2;
   localparam int SQ_IN_W = VAR_W + ODD;
   localparam int SQ_W    = 2 * ((SQ_IN_W + 1) / 2);
   localparam int MP_W    = (D_W > COUNT_WIDTH) ? D_W : COUNT_WIDTH;
   localparam int CNT_W   = $clog2(PROD_W + 1);

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic signed [SAMPLE_WIDTH-1:0] min_ff, min_in, max_ff, max_in;
   logic signed [MEAN_W-1:0]      mean_ff, mean_in;
   logic [VAR_W-1:0]              var_ff, var_in;
   logic signed [MEAN_W-1:0]      x_ff, x_in;
   logic [D_W-1:0]                diff_ff, diff_in;
   logic [D_W-1:0]                d1mag_ff, d1mag_in;
   logic                          d1neg_ff, d1neg_in;
   logic [PROD_W-1:0]             opa_ff, opa_in, opb_ff, opb_in;
   logic [MP_W-1:0]               mplier_ff, mplier_in;
   logic [COUNT_WIDTH-1:0]        rem_ff, rem_in;
   logic [SQ_W-1:0]               bit_ff, bit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0]        o_count_ff, o_count_in;
   logic signed [SAMPLE_WIDTH-1:0] o_min_ff, o_min_in, o_max_ff, o_max_in;
   logic [SAMPLE_WIDTH-1:0]       o_range_ff, o_range_in;
   logic signed [MEAN_W-1:0]      o_mean_ff, o_mean_in;
   logic [VAR_W-1:0]              o_var_ff, o_var_in;
   logic [STD_W-1:0]              o_std_ff, o_std_in;

   logic [PROD_W-1:0]             alu_a, alu_b, alu_y;
   logic                          alu_sub, alu_c;
   logic [COUNT_WIDTH:0]          rem_sh;
   logic [D_W-1:0]                mag;
   logic [SQ_W-1:0]               trial;
   logic                          accept, loop_end, first;
   logic [COUNT_WIDTH-1:0]        cnt_base;

   rmvs_alu #(.WIDTH(PROD_W)) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_y),
      .carry  (alu_c)
   );

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign loop_end = (cnt_ff == CNT_W'(1));
   assign rem_sh   = {rem_ff, opa_ff[PROD_W-1]};
   assign mag      = diff_ff[D_W-1] ? alu_y[D_W-1:0] : diff_ff;
   assign trial    = opb_ff[SQ_W-1:0] | bit_ff;
   assign cnt_base = req_restart ? '0 : count_ff;
   assign first    = (cnt_base == '0);

   // shared unit operand selection
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      case (state_ff)
         ST_D1, ST_D2: begin
            alu_a = {{(PROD_W-MEAN_W){x_ff[MEAN_W-1]}}, x_ff};
            alu_b = {{(PROD_W-MEAN_W){mean_ff[MEAN_W-1]}}, mean_ff};
         end
         ST_M1, ST_M2: begin
            alu_b = {{(PROD_W-D_W){diff_ff[D_W-1]}}, diff_ff};
         end
         ST_DIV1, ST_DIV2: begin
            alu_a = PROD_W'(rem_sh);
            alu_b = PROD_W'(count_ff);
         end
         ST_MEAN: begin
            alu_a   = {{(PROD_W-MEAN_W){mean_ff[MEAN_W-1]}}, mean_ff};
            alu_b   = PROD_W'(opa_ff[D_W-1:0]);
            alu_sub = d1neg_ff;
         end
         ST_MUL1, ST_MUL2: begin
            alu_a   = opa_ff;
            alu_b   = opb_ff;
            alu_sub = 1'b0;
         end
         ST_TSH: begin
            alu_a = PROD_W'(count_ff);
            alu_b = PROD_W'(1);
         end
         ST_SQRT: begin
            alu_a = opa_ff;
            alu_b = PROD_W'(trial);
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      x_in         = x_ff;
      diff_in      = diff_ff;
      d1mag_in     = d1mag_ff;
      d1neg_in     = d1neg_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      mplier_in    = mplier_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_count_in   = o_count_ff;
      o_min_in     = o_min_ff;
      o_max_in     = o_max_ff;
      o_range_in   = o_range_ff;
      o_mean_in    = o_mean_ff;
      o_var_in     = o_var_ff;
      o_std_in     = o_std_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = (&cnt_base) ? cnt_base : cnt_base + COUNT_WIDTH'(1);
               if (first) begin
                  min_in = req_sample;
                  max_in = req_sample;
               end else begin
                  if (req_sample > max_ff) max_in = req_sample;
                  if (req_sample < min_ff) min_in = req_sample;
               end
               if (req_restart) begin
                  mean_in = '0;
                  var_in  = '0;
               end
               x_in     = {req_sample, {FRAC_BITS{1'b0}}};
               state_in = ST_D1;
            end
         end
         ST_D1: begin
            diff_in  = alu_y[D_W-1:0];
            state_in = ST_M1;
         end
         ST_M1: begin
            d1mag_in = mag;
            d1neg_in = diff_ff[D_W-1];
            opa_in   = PROD_W'(mag);
            rem_in   = '0;
            cnt_in   = CNT_W'(PROD_W);
            state_in = ST_DIV1;
         end
         ST_DIV1, ST_DIV2: begin
            // restoring divide by the count, quotient shifts in at the bottom
            rem_in = alu_c ? alu_y[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
            opa_in = {opa_ff[PROD_W-2:0], alu_c};
            cnt_in = cnt_ff - CNT_W'(1);
            if (loop_end) state_in = (state_ff == ST_DIV1) ? ST_MEAN : ST_VLD;
         end
         ST_MEAN: begin
            mean_in  = alu_y[MEAN_W-1:0];
            state_in = ST_D2;
         end
         ST_D2: begin
            diff_in  = alu_y[D_W-1:0];
            state_in = ST_M2;
         end
         ST_M2: begin
            mplier_in = MP_W'(mag);
            opb_in    = PROD_W'(d1mag_ff);
            opa_in    = '0;
            cnt_in    = CNT_W'(D_W);
            state_in  = ST_MUL1;
         end
         ST_MUL1, ST_MUL2: begin
            if (mplier_ff[0]) opa_in = alu_y;
            opb_in    = opb_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (loop_end) begin
               if (state_ff == ST_MUL1) begin
                  state_in = ST_TSH;
               end else begin
                  rem_in   = '0;
                  cnt_in   = CNT_W'(PROD_W);
                  state_in = ST_DIV2;
               end
            end
         end
         ST_TSH: begin
            // product term truncated to fraction bits seeds the accumulator
            opa_in    = opa_ff >> FRAC_BITS;
            opb_in    = PROD_W'(var_ff);
            mplier_in = MP_W'(alu_y[COUNT_WIDTH-1:0]);
            cnt_in    = CNT_W'(COUNT_WIDTH);
            state_in  = ST_MUL2;
         end
         ST_VLD: begin
            var_in   = opa_ff[VAR_W-1:0];
            opa_in   = PROD_W'(opa_ff[VAR_W-1:0]) << ODD;
            opb_in   = '0;
            bit_in   = SQ_W'(1) << (SQ_W - 2);
            cnt_in   = CNT_W'(SQ_W / 2);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (alu_c) begin
               opa_in = alu_y;
               opb_in = PROD_W'((opb_ff[SQ_W-1:0] >> 1) | bit_ff);
            end else begin
               opb_in = PROD_W'(opb_ff[SQ_W-1:0] >> 1);
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - CNT_W'(1);
            if (loop_end) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_count_in   = count_ff;
               o_min_in     = min_ff;
               o_max_in     = max_ff;
               o_range_in   = SAMPLE_WIDTH'(max_ff - min_ff);
               o_mean_in    = mean_ff;
               o_var_in     = var_ff;
               o_std_in     = opb_ff[STD_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         mean_ff      <= '0;
         var_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      diff_ff    <= diff_in;
      d1mag_ff   <= d1mag_in;
      d1neg_ff   <= d1neg_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      mplier_ff  <= mplier_in;
      rem_ff     <= rem_in;
      bit_ff     <= bit_in;
      o_count_ff <= o_count_in;
      o_min_ff   <= o_min_in;
      o_max_ff   <= o_max_in;
      o_range_ff <= o_range_in;
      o_mean_ff  <= o_mean_in;
      o_var_ff   <= o_var_in;
      o_std_ff   <= o_std_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_count   = o_count_ff;
   assign rsp_min_value      = o_min_ff;
   assign rsp_max_value      = o_max_ff;
   assign rsp_value_range    = o_range_ff;
   assign rsp_mean_value     = o_mean_ff;
   assign rsp_variance_value = o_var_ff;
   assign rsp_std_deviation  = o_std_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done step");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (o_min_ff <= o_max_ff))
      else $error("reported minimum above maximum");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (o_count_ff != '0))
      else $error("result with zero count");

endmodule

// File: tb/sv/running_mean_variance_stats_tb.sv
module running_mean_variance_stats_tb;

   typedef struct {
      logic signed [15:0] sample;
      logic               restart;
   } sample_item_type;

   typedef struct {
      logic [31:0]        count;
      logic signed [15:0] min_v;
      logic signed [15:0] max_v;
      logic [15:0]        span;
      logic signed [31:0] mean;
      logic [46:0]        variance;
      logic [23:0]        std_dev;
   } stats_type;

   localparam int HOLD_CYCLES = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic signed [15:0] req_sample = '0;
   logic req_restart = 1'b0;
   logic rsp_stall = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic [31:0] rsp_sample_count;
   logic signed [15:0] rsp_min_value;
   logic signed [15:0] rsp_max_value;
   logic [15:0] rsp_value_range;
   logic signed [31:0] rsp_mean_value;
   logic [46:0] rsp_variance_value;
   logic [23:0] rsp_std_deviation;

   sample_item_type pending_samples[$];
   stats_type expected_stats[$];

   // predictor state
   logic [31:0]        st_count;
   logic signed [15:0] st_min;
   logic signed [15:0] st_max;
   logic signed [63:0] st_mean;
   logic [46:0]        st_var;

   int send_idle_pct = 35;
   int recv_idle_pct = 59;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int errors = 0;
   int samples_taken = 0;
   int results_checked = 0;
   int restarts_taken = 0;

   running_mean_variance_stats dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("running_mean_variance_stats: mismatch");
      $finish;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = '0;
      bitv = 64'h1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // welford update, returns the statistics after this sample
   function automatic stats_type welford_update(sample_item_type it);
      stats_type r;
      logic signed [63:0] x, d1, d2, mean_next;
      logic [63:0] n;
      logic [127:0] t, acc;
      if (it.restart) begin
         st_count = '0;
         st_min = '0;
         st_max = '0;
         st_mean = '0;
         st_var = '0;
      end
      if (st_count == 0) begin
         st_min = it.sample;
         st_max = it.sample;
      end else begin
         if (it.sample > st_max) st_max = it.sample;
         if (it.sample < st_min) st_min = it.sample;
      end
      if (st_count != 32'hFFFF_FFFF) st_count = st_count + 1;
      n = 64'(st_count);
      x = 64'(it.sample) * 64'sd65536;
      d1 = x - st_mean;
      mean_next = st_mean + d1 / $signed(n);
      d2 = x - mean_next;
      t = ({64'b0, magnitude(d1)} * {64'b0, magnitude(d2)}) >> 16;
      acc = ({81'b0, st_var} * {64'b0, n - 64'd1} + t) / {64'b0, n};
      st_var = acc[46:0];
      st_mean = mean_next;
      r.count = st_count;
      r.min_v = st_min;
      r.max_v = st_max;
      r.span = 16'(st_max - st_min);
      r.mean = st_mean[31:0];
      r.variance = st_var;
      r.std_dev = 24'(int_sqrt({17'b0, st_var}));
      return r;
   endfunction

   // driver: offers the next pending item, idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         st_count = '0;
         st_min = '0;
         st_max = '0;
         st_mean = '0;
         st_var = '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_stats.push_back(welford_update('{req_sample, req_restart}));
            samples_taken++;
            if (req_restart) restarts_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_sample <= pending_samples[0].sample;
               req_restart <= pending_samples[0].restart;
               void'(pending_samples.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t %s expected %0h actual %0h", $time, field, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats.size() == 0) begin
            $display("%0t unexpected result, expected none actual count %0h",
                     $time, rsp_sample_count);
            errors++;
         end else begin
            e = expected_stats.pop_front();
            report("sample_count", 64'(e.count), 64'(rsp_sample_count));
            report("min_value", 64'(e.min_v), 64'(rsp_min_value));
            report("max_value", 64'(e.max_v), 64'(rsp_max_value));
            report("value_range", 64'(e.span), 64'(rsp_value_range));
            report("mean_value", 64'(e.mean), 64'(rsp_mean_value));
            report("variance_value", 64'(e.variance), 64'(rsp_variance_value));
            report("std_deviation", 64'(e.std_dev), 64'(rsp_std_deviation));
            results_checked++;
         end
      end
   end

   task automatic push_sample(int value, bit restart);
      pending_samples.push_back('{16'(value), restart});
   endtask

   // runs: usually a restart first, then a stream around some center or over the full range
   task automatic push_runs(int total);
      int left, len, center, spread;
      left = total;
      while (left > 0) begin
         len = $urandom_range(40, 1);
         if (len > left) len = left;
         center = int'($urandom_range(65535)) - 32768;
         case ($urandom_range(3))
            0: spread = 0;
            1: spread = $urandom_range(16);
            2: spread = $urandom_range(2000);
            default: spread = 65536;
         endcase
         for (int i = 0; i < len; i++) begin
            int v;
            bit rs;
            if (spread >= 65536) v = int'($urandom_range(65535)) - 32768;
            else v = center + int'($urandom_range(2 * spread)) - spread;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            rs = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
            push_sample(v, rs);
         end
         left -= len;
      end
   endtask

   task automatic wait_drained();
      while (pending_samples.size() > 0 || expected_stats.size() > 0 || req_valid)
         @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: extremes, alternating extremes, restarts
      push_sample(-32768, 1'b0);
      push_sample(32767, 1'b0);
      push_sample(-32768, 1'b0);
      push_sample(32767, 1'b0);
      push_sample(0, 1'b0);
      push_sample(-1, 1'b0);
      push_sample(32767, 1'b1);
      push_sample(32767, 1'b0);
      push_sample(32767, 1'b0);
      push_sample(-32768, 1'b1);
      push_sample(-32768, 1'b0);
      push_sample(32767, 1'b0);
      push_sample(1, 1'b1);
      push_sample(-1, 1'b0);
      push_sample(21845, 1'b0);
      push_sample(-21846, 1'b0);
      push_sample(0, 1'b1);
      push_sample(0, 1'b0);
      push_sample(32767, 1'b0);
      push_sample(-32768, 1'b0);
      wait_drained();
      push_runs(150);
      @(negedge clock);
      hold_req = hold_req + 1;
      push_runs(150);
      // sender pauses until everything is back
      wait_drained();
      send_idle_pct = 59;
      recv_idle_pct = 35;
      push_runs(300);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_runs(300);
      wait_drained();
      repeat (300) @(posedge clock);
      $display("%0d samples (%0d with restart) through three idling phases, %0d results checked",
               samples_taken, restarts_taken, results_checked);
      if (errors == 0 && expected_stats.size() == 0) begin
         $display("running_mean_variance_stats: match");
      end else begin
         $display("running_mean_variance_stats: mismatch");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/rmvs_pkg.sv
rtl/core/rmvs_alu.sv
rtl/core/running_mean_variance_stats.sv
tb/sv/running_mean_variance_stats_tb.sv
